FILE: hw/rtl/qdn_pkg.sv
package qdn_pkg;

  localparam int QDN_QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 15;

  localparam logic [7:0]  CFG_RST_INPUT_ZP   = 8'd0;
  localparam logic [7:0]  CFG_RST_WEIGHT_ZP  = 8'd0;
  localparam logic [14:0] CFG_RST_SCALE_MULT = 15'd16384;
  localparam logic [4:0]  CFG_RST_SCALE_SHFT = 5'd0;
  localparam logic [7:0]  CFG_RST_OUTPUT_ZP  = 8'd0;

  // rounding nudge ahead of the divide by 2^15
  localparam logic signed [47:0] RQ_NUDGE  = 48'sd16384;
  localparam logic signed [33:0] OUT_MIN   = 34'sd0;
  localparam logic signed [33:0] OUT_MAX   = 34'sd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_ZP   = 3'd0,
    CFG_WEIGHT_ZP  = 3'd1,
    CFG_SCALE_MULT = 3'd2,
    CFG_SCALE_SHFT = 3'd3,
    CFG_OUTPUT_ZP  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  input_zp;
    logic [7:0]  weight_zp;
    logic [14:0] scale_mult;
    logic [4:0]  scale_shift;
    logic [7:0]  output_zp;
  } cfg_t;

  typedef struct packed {
    logic signed [8:0] act_off;
    logic signed [8:0] wgt_off;
    logic [31:0]       bias;
    logic              last;
  } item_t;

endpackage

FILE: hw/rtl/qdn_front.sv
module qdn_front import qdn_pkg::*; #(
  parameter int DEPTH = QDN_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_activation,
  input  logic [7:0]  in_weight,
  input  logic [31:0] in_bias,
  input  logic        in_last,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic             push;
  item_t            item_nxt;

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    item_nxt.act_off = $signed({1'b0, in_activation}) - $signed({1'b0, cfg.input_zp});
    item_nxt.wgt_off = $signed({1'b0, in_weight}) - $signed({1'b0, cfg.weight_zp});
    item_nxt.bias    = in_bias;
    item_nxt.last    = in_last;
    wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/qdn_mac.sv
module qdn_mac import qdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic        rq_ready,
  output logic        rq_push,
  output logic [31:0] rq_sum
);

  logic [31:0]       acc_r, acc_nxt;
  logic signed [17:0] prod;
  logic [31:0]       prod_ext;
  logic [31:0]       acc_sum;

  always_comb begin
    prod     = q_item.act_off * q_item.wgt_off;
    prod_ext = {{14{prod[17]}}, prod};
    acc_sum  = acc_r + prod_ext;
    rq_sum   = acc_sum + q_item.bias;
    q_pop    = q_valid && (!q_item.last || rq_ready);
    rq_push  = q_valid && q_item.last && rq_ready;
    acc_nxt  = q_item.last ? '0 : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (q_pop) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

FILE: hw/rtl/qdn_requant.sv
module qdn_requant import qdn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        rq_push,
  input  logic [31:0] rq_sum,
  output logic        rq_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_neuron_out
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  logic signed [31:0] sum_r;
  logic signed [47:0] prod_r, prod_nxt;
  logic signed [31:0] q_r, q_nxt;
  logic [7:0]         out_r, out_nxt;

  logic signed [47:0] nudged;
  logic [31:0]        mask, rem, thresh;
  logic signed [31:0] floored;
  logic signed [33:0] rounded, biased;

  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign rq_ready = en1;

  assign out_valid      = v4_r;
  assign out_neuron_out = out_r;

  always_comb begin
    prod_nxt = sum_r * $signed({1'b0, cfg.scale_mult});
    // the divide of the nudged product by 2^15 is a floor (bit select), also for negative products
    nudged   = prod_r + RQ_NUDGE;
    q_nxt    = nudged[46:15];
    // rounding shift, half away from zero
    mask     = ~(32'hFFFF_FFFF << cfg.scale_shift);
    rem      = q_r & mask;
    thresh   = (mask >> 1) + {31'd0, q_r[31]};
    floored  = q_r >>> cfg.scale_shift;
    rounded  = {{2{floored[31]}}, floored} + ((rem > thresh) ? 34'sd1 : 34'sd0);
    biased   = rounded + $signed({26'd0, cfg.output_zp});
    if (biased < OUT_MIN) begin
      out_nxt = '0;
    end else if (biased > OUT_MAX) begin
      out_nxt = OUT_MAX[7:0];
    end else begin
      out_nxt = biased[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && rq_push) begin
      sum_r <= rq_sum;
    end
    if (en2 && v1_r) begin
      prod_r <= prod_nxt;
    end
    if (en3 && v2_r) begin
      q_r <= q_nxt;
    end
    if (en4 && v3_r) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= rq_push;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

endmodule

FILE: hw/rtl/quantized_dense_neuron.sv
// One neuron of a uint8 quantized fully connected layer.
// Input channel (in_valid/in_stall): one activation/weight pair per
// transfer; in_bias is used on the transfer with in_last set, which closes
// the dot product. Output channel (out_valid/out_stall): one requantized
// byte per neuron.
// Throughput: one input transfer per cycle while neither channel stalls,
// set by the single 9x9 multiply-accumulate that drains the input queue.
// A result passes the queue, MAC, 32x15 multiply, nudge/divide and
// round/offset/clamp registers in that order before out_valid, and
// waits longer when the receiver stalls.
// A stalled result holds in the output register; the requant stages and
// the input queue keep filling behind it, and in_stall rises only once the
// queue is full.
// Configuration: cfg_write_en writes register cfg_index with cfg_wdata;
// indexes above four are ignored. Write only while idle.
// Reset (rst_n low, synchronous) clears the accumulator, the queue and all
// valid flags, and loads the register defaults (multiplier 16384).
module quantized_dense_neuron import qdn_pkg::*; #(
  parameter int QUEUE_DEPTH = QDN_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_activation,
  input  logic [7:0]            in_weight,
  input  logic signed [31:0]    in_bias,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_neuron_out
);

  cfg_t        cfg_r;
  logic        q_valid;
  item_t       q_item;
  logic        q_pop;
  logic        rq_ready;
  logic        rq_push;
  logic [31:0] rq_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.input_zp    <= CFG_RST_INPUT_ZP;
      cfg_r.weight_zp   <= CFG_RST_WEIGHT_ZP;
      cfg_r.scale_mult  <= CFG_RST_SCALE_MULT;
      cfg_r.scale_shift <= CFG_RST_SCALE_SHFT;
      cfg_r.output_zp   <= CFG_RST_OUTPUT_ZP;
    end else if (cfg_write_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INPUT_ZP:   cfg_r.input_zp    <= cfg_wdata[7:0];
        CFG_WEIGHT_ZP:  cfg_r.weight_zp   <= cfg_wdata[7:0];
        CFG_SCALE_MULT: cfg_r.scale_mult  <= cfg_wdata[14:0];
        CFG_SCALE_SHFT: cfg_r.scale_shift <= cfg_wdata[4:0];
        CFG_OUTPUT_ZP:  cfg_r.output_zp   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  qdn_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_activation (in_activation),
    .in_weight     (in_weight),
    .in_bias       (in_bias),
    .in_last       (in_last),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  qdn_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .rq_ready (rq_ready),
    .rq_push  (rq_push),
    .rq_sum   (rq_sum)
  );

  qdn_requant u_requant (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .rq_push        (rq_push),
    .rq_sum         (rq_sum),
    .rq_ready       (rq_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_neuron_out (out_neuron_out)
  );

endmodule

FILE: hw/rtl/qdn_checker.sv
module qdn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_neuron_out
);

  // neurons closed at the input and not yet delivered
  logic [7:0] pending_r;
  logic       last_xfer;
  logic       out_xfer;

  assign last_xfer = in_valid && !in_stall && in_last;
  assign out_xfer  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (last_xfer && !out_xfer) begin
      pending_r <= pending_r + 1'b1;
    end else if (!last_xfer && out_xfer) begin
      pending_r <= pending_r - 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_neuron_out))
    else $error("stalled result changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 8'd0)
    else $error("result without a closed neuron");

  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    last_xfer && pending_r == 8'd0 |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind quantized_dense_neuron qdn_checker u_qdn_checker (.*);
